### src/wisc_pkg.sv
// Shared types, constants and modular helpers for the weighted inversion sum block.
// No dependencies; every other file imports this package.

package wisc_pkg;

    localparam int KEY_W    = 7;
    localparam int WEIGHT_W = 30;
    // Wide enough for a position or an item count at the largest supported row length.
    localparam int IDX_W    = 13;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [IDX_W-1:0]    idx_t;

    localparam weight_t MODULUS = 30'd1000000007;

    // Register index of the one configuration register.
    localparam logic REG_LENGTH_IN_USE = 1'b0;

    typedef struct packed {
        key_t    key;
        weight_t weight;
    } item_t;

    // Operation context handed from the sequencer to the accumulator.
    typedef struct packed {
        logic  is_load;
        idx_t  p;
        idx_t  r;
        idx_t  count;
        item_t a;
        item_t b;
    } ctx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_APPLY,
        ST_DRAIN,
        ST_FOLD,
        ST_SUB,
        ST_ADD,
        ST_POST
    } state_t;

    function automatic weight_t mod_add(weight_t a, weight_t b);
        logic [WEIGHT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS})
        begin
            s = s - {1'b0, MODULUS};
        end
        return s[WEIGHT_W-1:0];
    endfunction

    function automatic weight_t mod_sub(weight_t a, weight_t b);
        weight_t d;
        if (a >= b)
        begin
            d = a - b;
        end
        else
        begin
            d = a + (MODULUS - b);
        end
        return d;
    endfunction

endpackage

### src/wisc_cell.sv
// One storage cell of the rotating item ring: holds one key and weight.
// Depends on wisc_pkg.

module wisc_cell
    import wisc_pkg::*;
(
    input  logic  clk,
    input  logic  shift_en,
    input  item_t item_in,
    output item_t item_out
);

    item_t item_reg;

    // Take the neighbor's item on every shift; hold otherwise.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            item_reg <= item_in;
        end
    end

    assign item_out = item_reg;

endmodule

### src/wisc_accum.sv
// Pair-term unit and accumulators: one ring entry per cycle while step_en is high, against the two swap slots.
// Depends on wisc_pkg.

module wisc_accum
    import wisc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    clear,
    input  logic    step_en,
    input  idx_t    q,
    input  item_t   head,
    input  ctx_t    ctx,
    output weight_t sum_old,
    output weight_t sum_new
);

    weight_t t_op_reg, t_or_reg, t_np_reg, t_nr_reg;
    weight_t t_op_next, t_or_next, t_np_next, t_nr_next;
    weight_t acc_op_reg, acc_or_reg, acc_np_reg, acc_nr_reg;
    weight_t sum_old_reg, sum_new_reg;
    weight_t pre_old, pre_new, pair_sum;
    logic    en, swap_en;

    // Term of the pair formed by entry q and the item sitting at slot x.
    function automatic weight_t pair_w(idx_t qi, idx_t x, item_t hq, item_t hx);
        logic inv;
        inv = (qi < x) ? (hq.key > hx.key) : (hx.key > hq.key);
        return inv ? mod_add(hq.weight, hx.weight) : '0;
    endfunction

    always_comb
    begin
        en        = step_en && (q < ctx.count) && (q != ctx.p) && (q != ctx.r);
        swap_en   = en && !ctx.is_load;
        t_op_next = swap_en ? pair_w(q, ctx.p, head, ctx.a) : '0;
        t_or_next = swap_en ? pair_w(q, ctx.r, head, ctx.b) : '0;
        t_np_next = en      ? pair_w(q, ctx.p, head, ctx.b) : '0;
        t_nr_next = swap_en ? pair_w(q, ctx.r, head, ctx.a) : '0;
        pair_sum  = mod_add(ctx.a.weight, ctx.b.weight);
        pre_old   = (!ctx.is_load && (ctx.a.key > ctx.b.key)) ? pair_sum : '0;
        pre_new   = (!ctx.is_load && (ctx.b.key > ctx.a.key)) ? pair_sum : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_op_reg    <= '0;
            t_or_reg    <= '0;
            t_np_reg    <= '0;
            t_nr_reg    <= '0;
            acc_op_reg  <= '0;
            acc_or_reg  <= '0;
            acc_np_reg  <= '0;
            acc_nr_reg  <= '0;
            sum_old_reg <= '0;
            sum_new_reg <= '0;
        end
        else
        begin
            if (clear)
            begin
                // Seed with the term of the swapped pair itself.
                t_op_reg   <= '0;
                t_or_reg   <= '0;
                t_np_reg   <= '0;
                t_nr_reg   <= '0;
                acc_op_reg <= pre_old;
                acc_or_reg <= '0;
                acc_np_reg <= pre_new;
                acc_nr_reg <= '0;
            end
            else
            begin
                t_op_reg   <= t_op_next;
                t_or_reg   <= t_or_next;
                t_np_reg   <= t_np_next;
                t_nr_reg   <= t_nr_next;
                acc_op_reg <= mod_add(acc_op_reg, t_op_reg);
                acc_or_reg <= mod_add(acc_or_reg, t_or_reg);
                acc_np_reg <= mod_add(acc_np_reg, t_np_reg);
                acc_nr_reg <= mod_add(acc_nr_reg, t_nr_reg);
            end
            sum_old_reg <= mod_add(acc_op_reg, acc_or_reg);
            sum_new_reg <= mod_add(acc_np_reg, acc_nr_reg);
        end
    end

    assign sum_old = sum_old_reg;
    assign sum_new = sum_new_reg;

endmodule

### src/weighted_inversion_sum_with_swaps.sv
// Top level of the weighted inversion sum block: ring of item cells, sequencer, total.
// Depends on wisc_pkg, wisc_cell and wisc_accum.
//
//  channel  | direction | beat contents
//  ---------+-----------+--------------------------------------------------------------
//  s_axis   | in        | tuser: kind; tdata: key, weight, first_pos, second_pos
//  m_axis   | out       | tdata: total (one beat per swap, none per load)
//  apb      | in        | one register, length_in_use, at byte address 0
//
// A swap passes ST_SCAN, ST_PREP, ST_APPLY, ST_DRAIN, ST_FOLD, ST_SUB, ST_ADD and ST_POST
// before the next beat is taken; a load skips ST_SCAN and ST_POST; a swap with a bad or
// equal position goes from accept straight to ST_POST. The item ring rotates one position
// per cycle in ST_SCAN and ST_APPLY: one full turn to fetch the two swap entries and one
// more turn to sum the pair terms and write the exchanged items back.
// Reset clears the count, the total and the control; the ring itself holds no reset.
// Input is taken only in idle; a stalled result holds in the output register and
// blocks the end of the following swap only.

module weighted_inversion_sum_with_swaps
    import wisc_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,   // [0] kind
    input  logic [55:0] s_axis_tdata,   // [6:0] key, [36:7] weight, [43:37] first_pos,
                                        // [50:44] second_pos, [55:51] zero
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [29:0] total, [31:30] zero
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = (CW > KEY_W) ? CW : KEY_W;
    localparam logic [IW-1:0] LAST_STEP = IW'(MAX_ITEMS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ITEMS);

    state_t         state_reg, state_next;
    logic [IW-1:0]  step_reg;
    logic [CW-1:0]  loaded_reg;
    logic [6:0]     len_reg;
    weight_t        total_reg;
    logic [IW-1:0]  p_reg, r_reg;
    item_t          a_reg, b_reg;
    logic           is_load_reg;
    logic           out_valid_reg;
    weight_t        out_total_reg;

    // sequencer strobes
    logic in_ready, accept, shift_en, acc_clear, step_en, step_last, out_load;

    // input beat fields
    logic          in_kind;
    key_t          in_key;
    weight_t       in_weight, in_weight_red;
    logic [6:0]    in_first, in_second, lo_pos, hi_pos;
    logic          full, swap_ok;

    // ring
    item_t cell_q [MAX_ITEMS];
    item_t tail_in;
    ctx_t  ctx;
    weight_t sum_old, sum_new;

    logic cfg_write;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH_IN_USE);
    assign prdata    = (paddr[2] == REG_LENGTH_IN_USE) ? {25'd0, len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 7'd64;
        end
        else if (cfg_write)
        begin
            len_reg <= pwdata[6:0];
        end
    end

    // ---------------- input decode ----------------
    assign in_kind   = s_axis_tuser;
    assign in_key    = s_axis_tdata[6:0];
    assign in_weight = s_axis_tdata[36:7];
    assign in_first  = s_axis_tdata[43:37];
    assign in_second = s_axis_tdata[50:44];

    // A 30-bit weight is below twice the modulus: one conditional subtract reduces it.
    assign in_weight_red = (in_weight >= MODULUS) ? (in_weight - MODULUS) : in_weight;

    // Drop loads past the smaller of the configured length and the ring size.
    assign full = (PW'(loaded_reg) >= PW'(len_reg)) || (loaded_reg >= FULL_COUNT);

    assign swap_ok = (in_first != 7'd0) && (in_second != 7'd0)
                   && (PW'(in_first) <= PW'(loaded_reg))
                   && (PW'(in_second) <= PW'(loaded_reg))
                   && (in_first != in_second);

    assign lo_pos = (in_first < in_second) ? in_first : in_second;
    assign hi_pos = (in_first < in_second) ? in_second : in_first;

    // ---------------- sequencer ----------------
    assign step_last = (step_reg == LAST_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        shift_en   = 1'b0;
        acc_clear  = 1'b0;
        step_en    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (in_kind)
                    begin
                        state_next = swap_ok ? ST_SCAN : ST_POST;
                    end
                    else
                    begin
                        state_next = full ? ST_IDLE : ST_PREP;
                    end
                end
            end
            ST_SCAN:
            begin
                // First turn: pick up both swap entries as they pass the head.
                shift_en = 1'b1;
                if (step_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                acc_clear  = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                // Second turn: sum pair terms and write exchanged items back.
                shift_en = 1'b1;
                step_en  = 1'b1;
                if (step_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = is_load_reg ? ST_IDLE : ST_POST;
            end
            ST_POST:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = in_ready;
    assign accept        = s_axis_tvalid && in_ready;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            loaded_reg    <= '0;
            total_reg     <= '0;
            is_load_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (shift_en)
            begin
                step_reg <= step_last ? '0 : step_reg + 1'b1;
            end
            if (accept)
            begin
                is_load_reg <= !in_kind;
            end
            if (state_reg == ST_SUB)
            begin
                total_reg <= mod_sub(total_reg, sum_old);
            end
            if (state_reg == ST_ADD)
            begin
                total_reg <= mod_add(total_reg, sum_new);
                if (is_load_reg)
                begin
                    loaded_reg <= loaded_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- operation context ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!in_kind)
            begin
                a_reg <= '{key: in_key, weight: in_weight_red};
                b_reg <= '{key: in_key, weight: in_weight_red};
                p_reg <= IW'(loaded_reg);
                r_reg <= IW'(loaded_reg);
            end
            else
            begin
                p_reg <= IW'(lo_pos - 7'd1);
                r_reg <= IW'(hi_pos - 7'd1);
            end
        end
        if (state_reg == ST_SCAN)
        begin
            if (step_reg == p_reg)
            begin
                a_reg <= cell_q[0];
            end
            if (step_reg == r_reg)
            begin
                b_reg <= cell_q[0];
            end
        end
        if (out_load)
        begin
            out_total_reg <= total_reg;
        end
    end

    // ---------------- item ring ----------------
    // The head entry wraps to the tail; on the second turn the swap slots (or the
    // append slot) take their new item instead.
    always_comb
    begin
        tail_in = cell_q[0];
        if (state_reg == ST_APPLY)
        begin
            if (step_reg == p_reg)
            begin
                tail_in = b_reg;
            end
            else if ((step_reg == r_reg) && !is_load_reg)
            begin
                tail_in = a_reg;
            end
        end
    end

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_ring
        if (i == MAX_ITEMS - 1)
        begin : g_tail
            wisc_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .item_in  (tail_in),
                .item_out (cell_q[i])
            );
        end
        else
        begin : g_body
            wisc_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .item_in  (cell_q[i+1]),
                .item_out (cell_q[i])
            );
        end
    end

    // ---------------- pair terms ----------------
    assign ctx = '{
        is_load: is_load_reg,
        p:       IDX_W'(p_reg),
        r:       IDX_W'(r_reg),
        count:   IDX_W'(loaded_reg),
        a:       a_reg,
        b:       b_reg
    };

    wisc_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (acc_clear),
        .step_en (step_en),
        .q       (IDX_W'(step_reg)),
        .head    (cell_q[0]),
        .ctx     (ctx),
        .sum_old (sum_old),
        .sum_new (sum_new)
    );

    // ---------------- result beat ----------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_total_reg};

endmodule

### src/wisc_checker.sv
// Port-level checks for the weighted inversion sum block, bound to its top level.
// Depends on wisc_pkg and weighted_inversion_sum_with_swaps.

module wisc_checker
    import wisc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // Every total is reduced and padded with zeros.
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[29:0] < MODULUS) && (m_axis_tdata[31:30] == 2'b00)))
        else $error("total out of range");

    // A load beat never starts a result beat right after it.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !$rose(m_axis_tvalid))
        else $error("result raised by a load");

endmodule

bind weighted_inversion_sum_with_swaps wisc_checker u_wisc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
